@@ rtl/ctm_pkg.sv @@
// shared types, constants and tone table for the ctcss tone mixer
package ctm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CODE_W     = 8;
    localparam int LEVEL_W    = 8;
    localparam int PHASE_W    = 15;
    localparam int INDEX_W    = 9;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int GAIN_SHIFT = 7;
    localparam int Q_SHIFT    = 15;
    localparam int ENTRY_W    = 6;

    localparam int TONE_TABLE_ENTRIES = 50;
    localparam int TONE_ROM_SIZE      = 50;
    localparam int TONE_LIMIT         = (TONE_TABLE_ENTRIES < TONE_ROM_SIZE) ?
                                        TONE_TABLE_ENTRIES : TONE_ROM_SIZE;

    localparam logic [CFG_IDX_W-1:0] REG_TONE_CODE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TONE_LEVEL = CFG_IDX_W'(1);

    typedef struct packed {
        logic               hit;
        logic [ENTRY_W-1:0] idx;
        logic [INDEX_W-1:0] len;
        logic [INDEX_W-1:0] inc;
    } t_tone;

    function automatic t_tone tone_lookup(input logic [CODE_W-1:0] code);
        t_tone t;
        t = '0;
        case (code)
            8'd67:  t = '{1'b1, 6'd0,  9'd358, 9'd92};
            8'd69:  t = '{1'b1, 6'd1,  9'd346, 9'd95};
            8'd71:  t = '{1'b1, 6'd2,  9'd334, 9'd99};
            8'd74:  t = '{1'b1, 6'd3,  9'd323, 9'd102};
            8'd77:  t = '{1'b1, 6'd4,  9'd312, 9'd106};
            8'd79:  t = '{1'b1, 6'd5,  9'd301, 9'd109};
            8'd82:  t = '{1'b1, 6'd6,  9'd291, 9'd113};
            8'd85:  t = '{1'b1, 6'd7,  9'd281, 9'd117};
            8'd88:  t = '{1'b1, 6'd8,  9'd271, 9'd121};
            8'd91:  t = '{1'b1, 6'd9,  9'd262, 9'd125};
            8'd94:  t = '{1'b1, 6'd10, 9'd253, 9'd130};
            8'd97:  t = '{1'b1, 6'd11, 9'd246, 9'd133};
            8'd100: t = '{1'b1, 6'd12, 9'd240, 9'd137};
            8'd103: t = '{1'b1, 6'd13, 9'd232, 9'd142};
            8'd107: t = '{1'b1, 6'd14, 9'd224, 9'd147};
            8'd110: t = '{1'b1, 6'd15, 9'd216, 9'd152};
            8'd114: t = '{1'b1, 6'd16, 9'd209, 9'd157};
            8'd118: t = '{1'b1, 6'd17, 9'd202, 9'd163};
            8'd123: t = '{1'b1, 6'd18, 9'd195, 9'd168};
            8'd127: t = '{1'b1, 6'd19, 9'd189, 9'd174};
            8'd131: t = '{1'b1, 6'd20, 9'd182, 9'd180};
            8'd136: t = '{1'b1, 6'd21, 9'd176, 9'd187};
            8'd141: t = '{1'b1, 6'd22, 9'd170, 9'd193};
            8'd146: t = '{1'b1, 6'd23, 9'd164, 9'd200};
            8'd151: t = '{1'b1, 6'd24, 9'd159, 9'd207};
            8'd156: t = '{1'b1, 6'd25, 9'd153, 9'd214};
            8'd159: t = '{1'b1, 6'd26, 9'd150, 9'd219};
            8'd162: t = '{1'b1, 6'd27, 9'd148, 9'd222};
            8'd165: t = '{1'b1, 6'd28, 9'd145, 9'd226};
            8'd167: t = '{1'b1, 6'd29, 9'd143, 9'd230};
            8'd171: t = '{1'b1, 6'd30, 9'd140, 9'd234};
            8'd173: t = '{1'b1, 6'd31, 9'd138, 9'd238};
            8'd177: t = '{1'b1, 6'd32, 9'd135, 9'd243};
            8'd179: t = '{1'b1, 6'd33, 9'd133, 9'd246};
            8'd183: t = '{1'b1, 6'd34, 9'd131, 9'd251};
            8'd186: t = '{1'b1, 6'd35, 9'd129, 9'd255};
            8'd189: t = '{1'b1, 6'd36, 9'd126, 9'd260};
            8'd192: t = '{1'b1, 6'd37, 9'd124, 9'd264};
            8'd196: t = '{1'b1, 6'd38, 9'd122, 9'd269};
            8'd199: t = '{1'b1, 6'd39, 9'd120, 9'd273};
            8'd203: t = '{1'b1, 6'd40, 9'd118, 9'd278};
            8'd206: t = '{1'b1, 6'd41, 9'd116, 9'd282};
            8'd210: t = '{1'b1, 6'd42, 9'd114, 9'd288};
            8'd218: t = '{1'b1, 6'd43, 9'd110, 9'd298};
            8'd225: t = '{1'b1, 6'd44, 9'd106, 9'd309};
            8'd229: t = '{1'b1, 6'd45, 9'd105, 9'd313};
            8'd233: t = '{1'b1, 6'd46, 9'd103, 9'd319};
            8'd241: t = '{1'b1, 6'd47, 9'd99,  9'd331};
            8'd250: t = '{1'b1, 6'd48, 9'd96,  9'd342};
            8'd254: t = '{1'b1, 6'd49, 9'd94,  9'd347};
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/ctm_ifs.sv @@
// request channel interfaces for samples in, samples out and register writes
interface ctm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ctm_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface ctm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ctm_pkg::SAMPLE_W-1:0] sample_out;
    logic                                tone_active;

    modport source (output valid, output sample_out, output tone_active, input ready);
    modport sink   (input valid, input sample_out, input tone_active, output ready);
endinterface

interface ctm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ctm_pkg::CFG_IDX_W-1:0]     index;
    logic [ctm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/ctm_sine_rom.sv @@
// sine lookup rom, one registered read port, contents built at elaboration
module ctm_sine_rom #(
    parameter int DEPTH = 512
) (
    input  logic                             i_clk,
    input  logic [$clog2(DEPTH+1)-1:0]       i_addr,
    output logic signed [ctm_pkg::SAMPLE_W-1:0] o_data
);

    localparam int                    EW         = ctm_pkg::SAMPLE_W;
    localparam longint unsigned       TWO_PI_Q30 = 64'd6746518852;

    function automatic logic signed [EW-1:0] sine_entry(input int unsigned n);
        longint unsigned  f;
        longint unsigned  r;
        longint unsigned  x;
        longint unsigned  x2;
        longint unsigned  term;
        longint unsigned  val;
        longint           sum;
        logic [1:0]       q;
        logic signed [EW-1:0] e;
        f = (longint'(n) << 30) / DEPTH;
        q = f[29:28];
        r = f & ((64'd1 << 28) - 64'd1);
        if (q[0]) begin
            r = (64'd1 << 28) - r;
        end
        x    = (r * TWO_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        val = (longint'(sum) * 32768 + (64'd1 << 29)) >> 30;
        if (val > 64'd32767) begin
            val = 64'd32767;
        end
        e = EW'(val);
        return q[1] ? -e : e;
    endfunction

    function automatic logic [EW*(DEPTH+1)-1:0] build_rom();
        logic [EW*(DEPTH+1)-1:0] v;
        v = '0;
        for (int i = 0; i <= DEPTH; i++) begin
            v[EW*i +: EW] = sine_entry(i % DEPTH);
        end
        return v;
    endfunction

    localparam logic [EW*(DEPTH+1)-1:0] ROM_BITS = build_rom();

    logic signed [EW-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= ROM_BITS[EW*i_addr +: EW];
    end

    assign o_data = r_data;

endmodule

@@ rtl/ctcss_tone_mixer_top.sv @@
// ctcss tone mixer top level: sequencer, shared multiplier and output register
// states: a known tone code goes idle, pos, rda, rdb, mulf, mulg, fin; an unknown one idle, fin
// samples are taken only in idle, after fin has put the last one in the output register; the
// single shared multiplier is used three times and the single rom port read twice per sample
// reset: synchronous active low; clears sequencer, output valid, registers, phase and index
module ctcss_tone_mixer_top #(
    parameter int SINE_ROM_DEPTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctm_in_if.sink      i_in,
    ctm_out_if.source   o_out,
    ctm_cfg_if.sink     i_cfg
);

    localparam int AW  = $clog2(SINE_ROM_DEPTH + 1);
    localparam int SW  = ctm_pkg::SAMPLE_W;
    localparam int QS  = ctm_pkg::Q_SHIFT;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POS  = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_RDB  = 3'd3;
    localparam logic [2:0] S_MULF = 3'd4;
    localparam logic [2:0] S_MULG = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]                         r_state, n_state;
    logic signed [SW-1:0]               r_x, n_x;
    logic                               r_active, n_active;
    logic signed [35:0]                 r_prod, n_prod;
    logic signed [SW-1:0]               r_a, n_a;
    logic [ctm_pkg::CODE_W-1:0]         r_code, n_code;
    logic [ctm_pkg::LEVEL_W-1:0]        r_level, n_level;
    logic [ctm_pkg::PHASE_W-1:0]        r_phase, n_phase;
    logic [ctm_pkg::INDEX_W-1:0]        r_index, n_index;
    logic                               r_out_valid, n_out_valid;
    logic signed [SW-1:0]               r_out_sample, n_out_sample;
    logic                               r_out_active, n_out_active;

    ctm_pkg::t_tone                     w_tone;
    logic                               w_hit;
    logic                               w_cfg_acc;
    logic                               w_out_free;
    logic [AW-1:0]                      w_rom_addr;
    logic signed [SW-1:0]               w_rom_q;
    logic signed [SW:0]                 w_diff;
    logic signed [SW:0]                 w_s;
    logic signed [17:0]                 w_mul_a, w_mul_b;
    logic signed [35:0]                 w_prod;
    logic signed [20:0]                 w_tone_full;
    logic signed [SW-1:0]               w_tone_sat;
    logic signed [SW-1:0]               w_sum;
    logic [ctm_pkg::INDEX_W-1:0]        w_index_inc;
    logic [ctm_pkg::PHASE_W-1:0]        w_phase_inc;

    ctm_sine_rom #(
        .DEPTH (SINE_ROM_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_q)
    );

    assign w_tone = ctm_pkg::tone_lookup(r_code);
    assign w_hit  = w_tone.hit &&
                    ({1'b0, w_tone.idx} < (ctm_pkg::ENTRY_W + 1)'(ctm_pkg::TONE_LIMIT));

    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.sample_out  = r_out_sample;
    assign o_out.tone_active = r_out_active;

    // rom address: integer part of phase times depth, then the next entry
    assign w_rom_addr = (r_state == S_RDB) ? (r_prod[QS +: AW] + AW'(1)) : r_prod[QS +: AW];

    assign w_diff = {w_rom_q[SW-1], w_rom_q} - {r_a[SW-1], r_a};
    assign w_s    = {r_a[SW-1], r_a} + r_prod[QS +: SW+1];

    always_comb begin
        case (r_state)
            S_POS: begin
                w_mul_a = $signed(18'({3'b0, r_phase}));
                w_mul_b = $signed(18'(SINE_ROM_DEPTH));
            end
            S_MULF: begin
                w_mul_a = 18'(w_diff);
                w_mul_b = $signed(18'({3'b0, r_prod[QS-1:0]}));
            end
            S_MULG: begin
                w_mul_a = 18'(w_s);
                w_mul_b = $signed(18'({r_level, {ctm_pkg::GAIN_SHIFT{1'b0}}}));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_tone_full = r_prod[QS +: 21];

    always_comb begin
        if (w_tone_full > 21'sd32767) begin
            w_tone_sat = 16'sh7fff;
        end else if (w_tone_full < -21'sd32768) begin
            w_tone_sat = -16'sh8000;
        end else begin
            w_tone_sat = SW'(w_tone_full);
        end
    end

    assign w_sum       = r_x + w_tone_sat;
    assign w_index_inc = r_index + ctm_pkg::INDEX_W'(1);
    assign w_phase_inc = ctm_pkg::PHASE_W'({1'b0, r_phase} + 16'(w_tone.inc));

    always_comb begin
        n_state      = r_state;
        n_x          = r_x;
        n_active     = r_active;
        n_prod       = r_prod;
        n_a          = r_a;
        n_code       = r_code;
        n_level      = r_level;
        n_phase      = r_phase;
        n_index      = r_index;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_active = r_out_active;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (w_cfg_acc) begin
            case (i_cfg.index)
                ctm_pkg::REG_TONE_CODE: begin
                    n_code  = i_cfg.data;
                    n_phase = '0;
                    n_index = '0;
                end
                ctm_pkg::REG_TONE_LEVEL: begin
                    n_level = i_cfg.data;
                    n_phase = '0;
                    n_index = '0;
                end
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_x      = i_in.sample_in;
                    n_active = w_hit;
                    n_state  = w_hit ? S_POS : S_FIN;
                end
            end
            S_POS: begin
                n_prod  = w_prod;
                n_state = S_RDA;
            end
            S_RDA: begin
                n_state = S_RDB;
            end
            S_RDB: begin
                n_a     = w_rom_q;
                n_state = S_MULF;
            end
            S_MULF: begin
                n_prod  = w_prod;
                n_state = S_MULG;
            end
            S_MULG: begin
                n_prod  = w_prod;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_active ? w_sum : r_x;
                    n_out_active = r_active;
                    if (r_active) begin
                        // end of tone period restarts phase and index
                        if (w_index_inc >= w_tone.len) begin
                            n_index = '0;
                            n_phase = '0;
                        end else begin
                            n_index = w_index_inc;
                            n_phase = w_phase_inc;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_code      <= '0;
            r_level     <= '0;
            r_phase     <= '0;
            r_index     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_code      <= n_code;
            r_level     <= n_level;
            r_phase     <= n_phase;
            r_index     <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x          <= n_x;
        r_active     <= n_active;
        r_prod       <= n_prod;
        r_a          <= n_a;
        r_out_sample <= n_out_sample;
        r_out_active <= n_out_active;
    end

    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished sample not presented on output");

    a_miss_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !w_hit) |=> (r_state == S_FIN && !r_active))
        else $error("unknown tone code did not take the pass-through path");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_acc && (i_cfg.index == ctm_pkg::REG_TONE_CODE ||
                       i_cfg.index == ctm_pkg::REG_TONE_LEVEL))
        |=> (r_phase == '0 && r_index == '0))
        else $error("register write did not restart phase and index");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_sample)))
        else $error("stalled result changed");

endmodule

@@ bench/ctm_mix_checker.sv @@
// checker for the ctcss tone mixer: watches all channels, predicts each mixed sample and compares
`timescale 1ns / 100ps

module ctm_mix_checker #(
    parameter int SINE_DEPTH = 512
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ctm_in_if    i_in,
    ctm_out_if   i_out,
    ctm_cfg_if   i_cfg,
    output int   o_mismatches,
    output int   o_pending
);

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               active;
    } mix_t;

    localparam int TONE_ROWS = 50;

    localparam logic [7:0] TONE_CODE_TAB [TONE_ROWS] = '{
         67,  69,  71,  74,  77,  79,  82,  85,  88,  91,
         94,  97, 100, 103, 107, 110, 114, 118, 123, 127,
        131, 136, 141, 146, 151, 156, 159, 162, 165, 167,
        171, 173, 177, 179, 183, 186, 189, 192, 196, 199,
        203, 206, 210, 218, 225, 229, 233, 241, 250, 254
    };

    localparam logic [8:0] TONE_LEN_TAB [TONE_ROWS] = '{
        358, 346, 334, 323, 312, 301, 291, 281, 271, 262,
        253, 246, 240, 232, 224, 216, 209, 202, 195, 189,
        182, 176, 170, 164, 159, 153, 150, 148, 145, 143,
        140, 138, 135, 133, 131, 129, 126, 124, 122, 120,
        118, 116, 114, 110, 106, 105, 103,  99,  96,  94
    };

    localparam logic [8:0] TONE_INC_TAB [TONE_ROWS] = '{
         92,  95,  99, 102, 106, 109, 113, 117, 121, 125,
        130, 133, 137, 142, 147, 152, 157, 163, 168, 174,
        180, 187, 193, 200, 207, 214, 219, 222, 226, 230,
        234, 238, 243, 246, 251, 255, 260, 264, 269, 273,
        278, 282, 288, 298, 309, 313, 319, 331, 342, 347
    };

    int          sine_tab [0:SINE_DEPTH];
    logic [7:0]  tone_code_q;
    logic [7:0]  tone_level_q;
    logic [8:0]  period_idx;
    logic [14:0] phase_acc;
    mix_t        mix_due [$];
    int          mismatches = 0;

    assign o_mismatches = mismatches;

    // q15 sine of n/SINE_DEPTH turns via quadrant-folded taylor series in q30
    function automatic int sine_point(input int unsigned n);
        u64_t        f;
        u64_t        r;
        u64_t        x;
        u64_t        x2;
        u64_t        term;
        u64_t        mag;
        longint      acc;
        int unsigned quad;
        f = (u64_t'(n) << 30) / u64_t'(SINE_DEPTH);
        quad = int'((f >> 28) & 64'd3);
        r = f & ((64'd1 << 28) - 64'd1);
        if (quad[0]) begin
            r = (64'd1 << 28) - r;
        end
        x = (r * 64'd6746518852) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        mag = (u64_t'(acc) * 64'd32768 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return (quad >= 2) ? -int'(mag) : int'(mag);
    endfunction

    initial begin
        for (int i = 0; i <= SINE_DEPTH; i++) begin
            sine_tab[i] = sine_point(i % SINE_DEPTH);
        end
    end

    function automatic int tone_row(input logic [7:0] code);
        for (int i = 0; i < ctm_pkg::TONE_LIMIT && i < TONE_ROWS; i++) begin
            if (TONE_CODE_TAB[i] == code) begin
                return i;
            end
        end
        return -1;
    endfunction

    // expected output for one sample, advances phase and period index when the tone code is known
    function automatic mix_t mix_sample(input logic signed [15:0] smp);
        int          row;
        int unsigned pos;
        int unsigned tab_idx;
        int unsigned frac;
        longint      acc;
        longint      sine;
        longint      tone;
        mix_t        r;
        row = tone_row(tone_code_q);
        if (row < 0) begin
            r.sample = smp;
            r.active = 1'b0;
            return r;
        end
        pos = 32'(phase_acc) * SINE_DEPTH;
        tab_idx = pos >> 15;
        frac = pos & 32'h7FFF;
        if (tab_idx >= SINE_DEPTH) begin
            tab_idx = SINE_DEPTH - 1;
        end
        acc = longint'(sine_tab[tab_idx]) * (64'sd32768 - longint'(frac))
            + longint'(sine_tab[tab_idx + 1]) * longint'(frac);
        sine = acc >>> 15;
        tone = (sine * longint'(tone_level_q) * 64'sd128) >>> 15;
        if (tone > 32767) begin
            tone = 32767;
        end
        if (tone < -32768) begin
            tone = -32768;
        end
        r.sample = smp + tone[15:0];
        r.active = 1'b1;
        period_idx = period_idx + 9'd1;
        phase_acc = phase_acc + 15'(TONE_INC_TAB[row]);
        if (period_idx >= TONE_LEN_TAB[row]) begin
            period_idx = '0;
            phase_acc = '0;
        end
        return r;
    endfunction

    task automatic report(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        mix_t want;
        if (!i_rst_n) begin
            tone_code_q = '0;
            tone_level_q = '0;
            period_idx = '0;
            phase_acc = '0;
            mix_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    ctm_pkg::REG_TONE_CODE: begin
                        tone_code_q = i_cfg.data;
                        period_idx = '0;
                        phase_acc = '0;
                    end
                    ctm_pkg::REG_TONE_LEVEL: begin
                        tone_level_q = i_cfg.data;
                        period_idx = '0;
                        phase_acc = '0;
                    end
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (mix_due.size() == 0) begin
                    report($sformatf("result %0d with no request pending", i_out.sample_out));
                end else begin
                    want = mix_due.pop_front();
                    if (i_out.sample_out !== want.sample) begin
                        report($sformatf("sample_out got %0d expected %0d",
                                         i_out.sample_out, want.sample));
                    end
                    if (i_out.tone_active !== want.active) begin
                        report($sformatf("tone_active got %b expected %b",
                                         i_out.tone_active, want.active));
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                mix_due.push_back(mix_sample(i_in.sample_in));
            end
        end
        o_pending <= mix_due.size();
    end

endmodule

@@ bench/tb.sv @@
// testbench top for the ctcss tone mixer: clock, reset, sample and register stimulus, verdict
`timescale 1ns / 100ps

module tb;

    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic sink_ready = 1'b0;
    int   mismatches;
    int   pending;
    int   sent       = 0;
    int   stall_mode = 0;
    int   stall_left = 0;

    ctm_in_if  in_ch ();
    ctm_out_if out_ch ();
    ctm_cfg_if cfg_ch ();

    assign out_ch.ready = sink_ready;

    ctcss_tone_mixer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ctm_mix_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

    // receiver stall pattern: full rate, coin flip, mostly stalled, rare stalls
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(30, 300);
        end
        stall_left--;
        case (stall_mode)
            0:       sink_ready <= 1'b1;
            1:       sink_ready <= 1'($urandom_range(0, 1));
            2:       sink_ready <= ($urandom_range(0, 7) == 0);
            default: sink_ready <= ($urandom_range(0, 15) != 0);
        endcase
    end

    task automatic send_sample(input logic [15:0] s);
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= s;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic end_burst(input int gap);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_code();
        logic [7:0]     c;
        ctm_pkg::t_tone t;
        case ($urandom_range(0, 9))
            0:       return 8'($urandom);
            1:       return $urandom_range(0, 1) ? 8'd67 : 8'd254;
            default: begin
                do begin
                    c = 8'($urandom);
                    t = ctm_pkg::tone_lookup(c);
                end while (!t.hit);
                return c;
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int burst;
        int plen;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first table entry at full level, sample extremes back to back
        write_reg(ctm_pkg::REG_TONE_CODE, 8'd67);
        write_reg(ctm_pkg::REG_TONE_LEVEL, 8'd255);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'h7FFF);
        end_burst(3);
        drain();

        // unknown codes pass samples through
        write_reg(ctm_pkg::REG_TONE_CODE, 8'd0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h1234);
        end_burst(2);
        drain();
        write_reg(ctm_pkg::REG_TONE_CODE, 8'd255);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        end_burst(1);
        drain();

        // last table entry with zero level still reports active
        write_reg(ctm_pkg::REG_TONE_CODE, 8'd254);
        write_reg(ctm_pkg::REG_TONE_LEVEL, 8'd0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        end_burst(2);
        drain();

        // writes to unused indexes must not restart the phase
        write_reg(ctm_pkg::REG_TONE_LEVEL, 8'd128);
        send_sample(16'h0100);
        send_sample(16'hFF00);
        send_sample(16'h0000);
        end_burst(1);
        drain();
        write_reg(8'd2, 8'hFF);
        write_reg(8'hFF, 8'h00);
        send_sample(16'h4000);
        send_sample(16'hC000);
        send_sample(16'h0000);
        end_burst(4);

        while (sent < 1600) begin
            drain();
            case ($urandom_range(0, 3))
                0: write_reg(ctm_pkg::REG_TONE_CODE, pick_code());
                1: write_reg(ctm_pkg::REG_TONE_LEVEL, pick_level());
                2: begin
                    write_reg(ctm_pkg::REG_TONE_CODE, pick_code());
                    write_reg(ctm_pkg::REG_TONE_LEVEL, pick_level());
                end
                default: begin
                    write_reg(ctm_pkg::REG_TONE_LEVEL, pick_level());
                    write_reg(ctm_pkg::REG_TONE_CODE, pick_code());
                end
            endcase
            if ($urandom_range(0, 4) == 0) begin
                write_reg(8'($urandom_range(2, 255)), 8'($urandom));
            end
            // some runs long enough to cross the longest tone period
            plen = ($urandom_range(0, 6) == 0) ? $urandom_range(360, 420) : $urandom_range(8, 80);
            while (plen > 0) begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
                                                      $urandom_range(1, 10);
                for (int b = 0; b < burst && plen > 0; b++) begin
                    send_sample(pick_sample());
                    plen--;
                end
                end_burst($urandom_range(1, 9));
                if ($urandom_range(0, 29) == 0) begin
                    drain();
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
